FILE: rtl/core/fuzzy_smc_heading_controller_unit_macros.svh
// assertion helpers shared by the checker
`ifndef FUZZY_SMC_HEADING_CONTROLLER_UNIT_MACROS_SVH
`define FUZZY_SMC_HEADING_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FSH_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("fsh assertion failed");

// next-cycle implication, disabled in reset
`define FSH_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("fsh assertion failed");

`endif

FILE: rtl/core/fsh_pkg.sv
`timescale 1ns / 1ps
package fsh_pkg;

  localparam logic [1:0] CFG_MAX_LIN  = 2'd0;
  localparam logic [1:0] CFG_MAX_TURN = 2'd1;
  localparam logic [1:0] CFG_MIN_TURN = 2'd2;

  localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [35:0] KINV_Q30   = 36'sd652032874;
  localparam logic signed [35:0] LOG2E_Q16  = 36'sd94548;
  localparam logic [14:0] HALF_PI_Q13  = 15'd12868;
  localparam logic [14:0] SAT_EDGE_Q13 = 15'd1229;
  localparam logic [16:0] MIN_TURN_EPS = 17'd41;
  localparam logic signed [17:0] GAIN_BIAS = 18'sd10240;
  localparam logic [17:0] POLY_SEED = 18'd87;
  localparam logic [15:0] RECIP3 = 16'd43691;

  typedef struct packed {
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] robot_heading;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
  } pose_t;

  typedef struct packed {
    logic [14:0]        linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               at_target;
  } cmd_t;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [15:0] heading;
    logic               near;
  } job_t;

  typedef struct packed {
    logic [14:0] max_lin;
    logic [14:0] max_turn;
    logic [14:0] min_turn;
  } cfg_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
    logic signed [35:0] v;
    case (idx)
      5'd0:  v = 36'sd843314857;
      5'd1:  v = 36'sd497837829;
      5'd2:  v = 36'sd263043837;
      5'd3:  v = 36'sd133525159;
      5'd4:  v = 36'sd67021687;
      5'd5:  v = 36'sd33543516;
      5'd6:  v = 36'sd16775851;
      5'd7:  v = 36'sd8388437;
      5'd8:  v = 36'sd4194283;
      5'd9:  v = 36'sd2097149;
      5'd10: v = 36'sd1048576;
      5'd11: v = 36'sd524288;
      5'd12: v = 36'sd262144;
      5'd13: v = 36'sd131072;
      5'd14: v = 36'sd65536;
      5'd15: v = 36'sd32768;
      5'd16: v = 36'sd16384;
      5'd17: v = 36'sd8192;
      5'd18: v = 36'sd4096;
      5'd19: v = 36'sd2048;
      5'd20: v = 36'sd1024;
      5'd21: v = 36'sd512;
      5'd22: v = 36'sd256;
      5'd23: v = 36'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // horner coefficients of 2^f, highest order seeded separately
  function automatic logic [17:0] poly_coef(input logic [2:0] idx);
    logic [17:0] v;
    case (idx)
      3'd0: v = 18'd630;
      3'd1: v = 18'd3638;
      3'd2: v = 18'd15743;
      3'd3: v = 18'd45426;
      3'd4: v = 18'd65536;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/fuzzy_smc_heading_controller_unit.sv
`timescale 1ns / 1ps
// Heading controller: each pose request yields one command of forward speed, turn rate
// and an at-target flag. A front stage forms the target offsets and parks up to two
// requests in a queue while the back engine works; the engine takes one request at a
// time and works it through one shared CORDIC run twice (bearing, then cosine),
// a five-step polynomial, a 15-step divider for the gain and 0 to 10 normalizing shifts
// of the offsets. The bearing run is skipped when the two points coincide, the cosine
// run when the heading error is at or beyond pi/2. The result waits in an output
// register, so the engine takes the next request at once; it stalls only in its final
// state while an earlier command is still waiting there.
module fuzzy_smc_heading_controller_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pose_valid,
  output logic           pose_ready,
  input  fsh_pkg::pose_t pose,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output fsh_pkg::cmd_t  cmd,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [14:0]    cfg_data
);

  fsh_pkg::cfg_t cfg;
  fsh_pkg::job_t push_job;
  fsh_pkg::job_t head;
  logic          push;
  logic          q_full;
  logic          head_valid;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_lin <= 15'd2048;
      cfg.max_turn <= 15'd4096;
      cfg.min_turn <= 15'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        fsh_pkg::CFG_MAX_LIN:  cfg.max_lin <= cfg_data;
        fsh_pkg::CFG_MAX_TURN: cfg.max_turn <= cfg_data;
        fsh_pkg::CFG_MIN_TURN: cfg.min_turn <= cfg_data;
        default: ;
      endcase
    end
  end

  fsh_front u_front (
    .pose_valid (pose_valid),
    .pose_ready (pose_ready),
    .pose       (pose),
    .q_full     (q_full),
    .push       (push),
    .job        (push_job)
  );

  fsh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  fsh_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head),
    .job_pop   (pop),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

endmodule

FILE: rtl/core/fsh_front.sv
`timescale 1ns / 1ps
module fsh_front (
  input  logic           pose_valid,
  output logic           pose_ready,
  input  fsh_pkg::pose_t pose,
  input  logic           q_full,
  output logic           push,
  output fsh_pkg::job_t  job
);

  logic signed [32:0] dx;
  logic signed [32:0] dy;

  always_comb begin
    dx = {pose.target_x[31], pose.target_x} - {pose.robot_x[31], pose.robot_x};
    dy = {pose.target_y[31], pose.target_y} - {pose.robot_y[31], pose.robot_y};
    job.dx = dx;
    job.dy = dy;
    job.heading = pose.robot_heading;
    // only offsets under one meter on both axes can be close
    job.near = (dx > -33'sd65536) && (dx < 33'sd65536) &&
               (dy > -33'sd65536) && (dy < 33'sd65536);
    pose_ready = !q_full;
    push = pose_valid && !q_full;
  end

endmodule

FILE: rtl/core/fsh_queue.sv
`timescale 1ns / 1ps
module fsh_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fsh_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output fsh_pkg::job_t head
);

  localparam int DEPTH = 2;

  fsh_pkg::job_t mem [DEPTH];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full = (cnt == 2'(DEPTH));
  assign head_valid = (cnt != 2'd0);
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

endmodule

FILE: rtl/core/fsh_back.sv
`timescale 1ns / 1ps
module fsh_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  fsh_pkg::job_t job,
  output logic          job_pop,
  input  fsh_pkg::cfg_t cfg,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output fsh_pkg::cmd_t cmd
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_SQX  = 15'b000000000000010,
    ST_SQY  = 15'b000000000000100,
    ST_NORM = 15'b000000000001000,
    ST_VEC  = 15'b000000000010000,
    ST_ERR  = 15'b000000000100000,
    ST_WRAP = 15'b000000001000000,
    ST_GAIN = 15'b000000010000000,
    ST_POLY = 15'b000000100000000,
    ST_DEN  = 15'b000001000000000,
    ST_DIV  = 15'b000010000000000,
    ST_ROT  = 15'b000100000000000,
    ST_MULA = 15'b001000000000000,
    ST_MULB = 15'b010000000000000,
    ST_FIN  = 15'b100000000000000
  } state_t;

  state_t state;

  logic signed [35:0] x;
  logic signed [35:0] y;
  logic signed [35:0] z;
  logic signed [15:0] hd;
  logic               near;
  logic               close;
  logic [32:0]        sq;
  logic [IW-1:0]      i;
  logic [2:0]         pcnt;
  logic [3:0]         dcnt;
  logic signed [15:0] e13;
  logic [14:0]        a13;
  logic signed [21:0] p16;
  logic [17:0]        t;
  logic [27:0]        denom;
  logic [27:0]        rem;
  logic [14:0]        q;
  logic [14:0]        k12;
  logic signed [17:0] sum;
  logic [30:0]        cosx;
  logic signed [33:0] prod;
  logic [14:0]        v12;

  // shared cordic step
  logic signed [35:0] xs, ys, at;
  logic signed [35:0] x_step, y_step, z_step;
  logic               rot_pos;

  always_comb begin
    xs = x >>> i;
    ys = y >>> i;
    at = fsh_pkg::atan_q30(5'(i));
    if (state == ST_VEC) rot_pos = y[35] || (y == 36'sd0);
    else rot_pos = !z[35];
    if (rot_pos) begin
      x_step = x - ys;
      y_step = y + xs;
      z_step = z - at;
    end else begin
      x_step = x + ys;
      y_step = y - xs;
      z_step = z + at;
    end
  end

  // magnitudes for squaring and normalizing
  logic [35:0] ax, ay, mx;
  always_comb begin
    ax = x[35] ? 36'(-x) : 36'(x);
    ay = y[35] ? 36'(-y) : 36'(y);
    mx = (ax > ay) ? ax : ay;
  end

  // one squarer shared by both offsets
  logic [15:0] sqin;
  logic [31:0] sqv;
  always_comb begin
    sqin = (state == ST_SQX) ? ax[15:0] : ay[15:0];
    sqv = sqin * sqin;
  end

  // heading error wrap and rounding
  logic signed [35:0] ew, rnd;
  always_comb begin
    if (z > fsh_pkg::PI_Q30) ew = z - fsh_pkg::TWO_PI_Q30;
    else if (z <= -fsh_pkg::PI_Q30) ew = z + fsh_pkg::TWO_PI_Q30;
    else ew = z;
    rnd = ew + 36'sd65536;
  end

  // gain argument, floor(-u*log2e) in q16
  logic [15:0]        e_abs;
  logic signed [17:0] u13;
  logic signed [35:0] mp;
  always_comb begin
    e_abs = e13[15] ? 16'(-e13) : 16'(e13);
    u13 = $signed({3'b000, e_abs[14:0]}) * 18'sd5 - fsh_pkg::GAIN_BIAS;
    mp = -(36'(u13)) * fsh_pkg::LOG2E_Q16;
  end

  logic [33:0] tf;
  assign tf = t * p16[15:0];

  // 2^n scaling of the polynomial result
  logic signed [5:0] n;
  logic [5:0]        nneg;
  logic [26:0]       w;
  always_comb begin
    n = p16[21:16];
    nneg = 6'(-n);
    if (!n[5]) begin
      if (n[4:3] == 2'b00) w = {9'b0, t} << n[2:0];
      else w = {9'b0, t} << 8;
    end else begin
      w = {9'b0, t} >> nneg;
    end
  end

  // restoring divide step
  logic [28:0] rem2;
  logic        ge;
  logic [14:0] q_new;
  always_comb begin
    rem2 = {rem, 1'b0};
    ge = (rem2 >= {1'b0, denom});
    q_new = {q[13:0], ge};
  end

  // sat term, trunc(20e/3) via reciprocal
  logic [14:0]        m20;
  logic [30:0]        m3;
  logic signed [15:0] s13;
  always_comb begin
    m20 = 15'(a13 * 15'd20);
    m3 = m20 * fsh_pkg::RECIP3;
    if (a13 >= fsh_pkg::SAT_EDGE_Q13) s13 = e13[15] ? -16'sd8192 : 16'sd8192;
    else s13 = e13[15] ? -$signed({2'b00, m3[30:17]}) : $signed({2'b00, m3[30:17]});
  end

  logic [45:0] vm;
  assign vm = cfg.max_lin * cosx;

  // final rounding and turn limits
  logic [33:0] pmag;
  logic [33:0] pr;
  logic [16:0] wmag;
  logic [16:0] wlim;
  always_comb begin
    pmag = prod[33] ? 34'(-prod) : 34'(prod);
    pr = pmag + 34'd8192;
    wmag = close ? 17'd0 : pr[30:14];
    if (wmag > {2'b00, cfg.max_turn}) wlim = {2'b00, cfg.max_turn};
    else if (wmag < {2'b00, cfg.min_turn} && wmag >= fsh_pkg::MIN_TURN_EPS)
      wlim = {2'b00, cfg.min_turn};
    else wlim = wmag;
  end

  assign job_pop = (state == ST_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_ready) cmd_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            x <= {{3{job.dx[32]}}, job.dx};
            y <= {{3{job.dy[32]}}, job.dy};
            hd <= job.heading;
            near <= job.near;
            state <= ST_SQX;
          end
        end
        ST_SQX: begin
          sq <= {1'b0, sqv};
          state <= ST_SQY;
        end
        ST_SQY: begin
          sq <= sq + {1'b0, sqv};
          state <= ST_NORM;
        end
        ST_NORM: begin
          if (mx == 36'd0) begin
            z <= '0;
            state <= ST_ERR;
          end else if (mx < 36'd4194304) begin
            x <= x <<< 8;
            y <= y <<< 8;
          end else if (mx < 36'd1073741824) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else begin
            // fold left half-plane onto the right
            if (x[35]) begin
              z <= y[35] ? -fsh_pkg::PI_Q30 : fsh_pkg::PI_Q30;
              x <= -x;
              y <= -y;
            end else begin
              z <= '0;
            end
            i <= '0;
            state <= ST_VEC;
          end
        end
        ST_VEC: begin
          x <= x_step;
          y <= y_step;
          z <= z_step;
          i <= i + 1'b1;
          if (i == LAST_STEP) state <= ST_ERR;
        end
        ST_ERR: begin
          z <= z - ({{20{hd[15]}}, hd} <<< 17);
          close <= near && ((40'(sq) * 40'd100) < 40'h1_0000_0000);
          state <= ST_WRAP;
        end
        ST_WRAP: begin
          e13 <= rnd[32:17];
          state <= ST_GAIN;
        end
        ST_GAIN: begin
          a13 <= e_abs[14:0];
          p16 <= mp[34:13];
          t <= fsh_pkg::POLY_SEED;
          pcnt <= '0;
          state <= ST_POLY;
        end
        ST_POLY: begin
          t <= fsh_pkg::poly_coef(pcnt) + tf[33:16];
          pcnt <= pcnt + 3'd1;
          if (pcnt == 3'd4) state <= ST_DEN;
        end
        ST_DEN: begin
          denom <= 28'd65536 + {1'b0, w};
          rem <= 28'd32768;
          q <= '0;
          dcnt <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= ge ? 28'(rem2 - {1'b0, denom}) : rem2[27:0];
          q <= q_new;
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd14) begin
            k12 <= 15'd4096 + q_new;
            sum <= (18'(e13) <<< 1) + 18'(s13);
            i <= '0;
            if (a13 >= fsh_pkg::HALF_PI_Q13) begin
              x <= '0;
              state <= ST_MULA;
            end else begin
              x <= fsh_pkg::KINV_Q30;
              y <= '0;
              z <= {4'b0, a13, 17'b0};
              state <= ST_ROT;
            end
          end
        end
        ST_ROT: begin
          x <= x_step;
          y <= y_step;
          z <= z_step;
          i <= i + 1'b1;
          if (i == LAST_STEP) state <= ST_MULA;
        end
        ST_MULA: begin
          prod <= $signed({1'b0, k12}) * sum;
          if (x[35]) cosx <= '0;
          else if (x > 36'sd1073741824) cosx <= 31'd1073741824;
          else cosx <= x[30:0];
          state <= ST_MULB;
        end
        ST_MULB: begin
          v12 <= vm[44:30];
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!cmd_valid || cmd_ready) begin
            cmd.linear_cmd <= close ? 15'd0 : v12;
            cmd.angular_cmd <= prod[33] ? -$signed(wlim[15:0]) : $signed(wlim[15:0]);
            cmd.at_target <= close;
            cmd_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/fsh_checker.sv
`timescale 1ns / 1ps
`include "fuzzy_smc_heading_controller_unit_macros.svh"
module fsh_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input fsh_pkg::cmd_t cmd
);

  `FSH_ASSERT_NEXT(a_cmd_hold, clk, rst, cmd_valid && !cmd_ready, cmd_valid)
  `FSH_ASSERT_NEXT(a_cmd_stable, clk, rst, cmd_valid && !cmd_ready, $stable(cmd))
  // commands are zeroed at the target
  `FSH_ASSERT_NOW(a_target_zero, clk, rst, cmd_valid && cmd.at_target, cmd.linear_cmd == 15'd0 && cmd.angular_cmd == 16'sd0)
  // limits keep the turn magnitude within 15 bits
  `FSH_ASSERT_NOW(a_turn_range, clk, rst, cmd_valid, cmd.angular_cmd != -16'sd32768)

endmodule

bind fuzzy_smc_heading_controller_unit fsh_checker u_fsh_checker (.*);
